FILE: hw/rtl/lbs_pkg.sv
// Shared types, widths and helper functions of the linear blend skinning block.
// No dependencies; every other file of the block imports this package.
package lbs_pkg;

   localparam int LANES       = 12;   // one lane per element of a 3x4 matrix
   localparam int INFL        = 4;    // influences per vertex
   localparam int ACC_W       = 51;   // lane sum of four word*weight products
   localparam int WSUM_W      = 18;   // sum of four 16-bit weights
   localparam int XACC_W      = 50;   // transform accumulators
   localparam int MAG_W       = 49;   // magnitude of a normal accumulator
   localparam int NMAG_W      = 30;   // magnitude after the normalizing shift
   localparam int DIV_NUM_W   = 50;
   localparam int DIV_DEN_W   = 31;
   localparam int DIV_CNT_W   = 6;
   localparam int SQ_IN_W     = 62;
   localparam int SQ_OUT_W    = 31;
   localparam int SQ_REM_W    = 34;
   localparam int SQ_CNT_W    = 5;

   localparam logic [WSUM_W-1:0] WSUM_LO = 18'd32736;
   localparam logic [WSUM_W-1:0] WSUM_HI = 18'd32800;
   localparam logic signed [31:0] Q16_ONE = 32'sd65536;
   localparam logic [14:0] NRM_MAX = 15'h7fff;

   // addr / 12 as (addr * 683) >> 13, exact for 10-bit addresses
   localparam logic [9:0] DIV12_MUL   = 10'd683;
   localparam int         DIV12_SHIFT = 13;

   localparam logic [3:0] DIAG_0 = 4'd0;
   localparam logic [3:0] DIAG_1 = 4'd5;
   localparam logic [3:0] DIAG_2 = 4'd10;

   typedef struct packed {
      logic        clear;
      logic        issue;
      logic [7:0]  joint;
      logic [15:0] weight;
   } lane_ctrl_type;

   typedef struct packed {
      logic        en;
      logic [7:0]  row;
      logic [31:0] data;
   } lane_wr_type;

   typedef enum logic [1:0] {
      MUL_POS,
      MUL_NRM,
      MUL_SQR
   } mul_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GATHER,
      ST_ELEM,
      ST_ELEM_WAIT,
      ST_XINIT,
      ST_XFORM,
      ST_SHIFT,
      ST_SQUARE,
      ST_SQRT,
      ST_NDIV,
      ST_NDIV_WAIT,
      ST_DONE
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      logic signed [31:0] r;
      if (x > 64'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (x < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = $signed(x[31:0]);
      end
      return r;
   endfunction

   function automatic logic is_diag(input logic [3:0] idx);
      return (idx == DIAG_0) || (idx == DIAG_1) || (idx == DIAG_2);
   endfunction

endpackage

FILE: hw/rtl/lbs_lane.sv
// One matrix-element lane: palette column memory and weighted multiply-accumulate.
// Depends on lbs_pkg.
module lbs_lane #(
   parameter int MAX_JOINTS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  lbs_pkg::lane_wr_type                wr,
   input  lbs_pkg::lane_ctrl_type              ctrl,
   output logic signed [lbs_pkg::ACC_W-1:0]    sum
);
   import lbs_pkg::*;

   localparam int JW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;

   logic [31:0]              mem [MAX_JOINTS];
   logic [31:0]              rd_ff;
   logic [15:0]              w1_ff;
   logic                     v1_ff;
   logic                     v2_ff;
   logic signed [48:0]       prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.row[JW-1:0]] <= wr.data;
      end
      if (ctrl.issue) begin
         rd_ff <= mem[ctrl.joint[JW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         acc_ff <= '0;
      end else begin
         v1_ff <= ctrl.issue;
         v2_ff <= v1_ff;
         if (ctrl.clear) begin
            acc_ff <= '0;
         end else if (v2_ff) begin
            acc_ff <= acc_ff + ACC_W'(prod_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      w1_ff   <= ctrl.weight;
      prod_ff <= $signed(rd_ff) * $signed({1'b0, w1_ff});
   end

   assign sum = acc_ff;

endmodule

FILE: hw/rtl/lbs_div.sv
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on lbs_pkg.
module lbs_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [lbs_pkg::DIV_NUM_W-1:0]      num,
   input  logic [lbs_pkg::DIV_DEN_W-1:0]      den,
   output logic                               done,
   output logic [lbs_pkg::DIV_NUM_W-1:0]      quo
);
   import lbs_pkg::*;

   logic [DIV_DEN_W:0]     rem_ff;
   logic [DIV_NUM_W-1:0]   quo_ff;
   logic [DIV_DEN_W-1:0]   den_ff;
   logic [DIV_CNT_W-1:0]   cnt_ff;
   logic                   run_ff;
   logic                   done_ff;
   logic [DIV_DEN_W:0]     rem_sh;
   logic                   ge;

   assign rem_sh = {rem_ff[DIV_DEN_W-1:0], quo_ff[DIV_NUM_W-1]};
   assign ge     = rem_sh >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
         end else if (run_ff && cnt_ff == DIV_CNT_W'(1)) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= num;
         den_ff <= den;
         cnt_ff <= DIV_CNT_W'(DIV_NUM_W);
      end else if (run_ff) begin
         rem_ff <= ge ? (rem_sh - {1'b0, den_ff}) : rem_sh;
         quo_ff <= {quo_ff[DIV_NUM_W-2:0], ge};
         cnt_ff <= cnt_ff - DIV_CNT_W'(1);
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

FILE: hw/rtl/lbs_sqrt.sv
// Digit-by-digit integer square root (floor), one result bit per cycle.
// Depends on lbs_pkg.
module lbs_sqrt (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [lbs_pkg::SQ_IN_W-1:0]      val,
   output logic                             done,
   output logic [lbs_pkg::SQ_OUT_W-1:0]     root
);
   import lbs_pkg::*;

   logic [SQ_REM_W-1:0]  rem_ff;
   logic [SQ_OUT_W-1:0]  root_ff;
   logic [SQ_IN_W-1:0]   val_ff;
   logic [SQ_CNT_W-1:0]  cnt_ff;
   logic                 run_ff;
   logic                 done_ff;
   logic [SQ_REM_W-1:0]  rem_sh;
   logic [SQ_REM_W-1:0]  trial;
   logic                 ge;

   assign rem_sh = {rem_ff[SQ_REM_W-3:0], val_ff[SQ_IN_W-1 -: 2]};
   assign trial  = {1'b0, root_ff, 2'b01};
   assign ge     = rem_sh >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
         end else if (run_ff && cnt_ff == SQ_CNT_W'(1)) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= '0;
         root_ff <= '0;
         val_ff  <= val;
         cnt_ff  <= SQ_CNT_W'(SQ_OUT_W);
      end else if (run_ff) begin
         rem_ff  <= ge ? (rem_sh - trial) : rem_sh;
         root_ff <= {root_ff[SQ_OUT_W-2:0], ge};
         val_ff  <= {val_ff[SQ_IN_W-3:0], 2'b00};
         cnt_ff  <= cnt_ff - SQ_CNT_W'(1);
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

FILE: hw/rtl/lbs_merge.sv
// Merge sequencer: gathers lane sums, normalizes the blended matrix, transforms
// position and normal, renormalizes the normal. Depends on lbs_pkg, lbs_div, lbs_sqrt.
module lbs_merge (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [8:0]                        limit,
   input  logic [31:0]                       joint_indices,
   input  logic [31:0]                       weights_01,
   input  logic [31:0]                       weights_23,
   input  logic signed [31:0]                pos_x,
   input  logic signed [31:0]                pos_y,
   input  logic signed [31:0]                pos_z,
   input  logic signed [15:0]                nrm_x,
   input  logic signed [15:0]                nrm_y,
   input  logic signed [15:0]                nrm_z,
   input  logic signed [lbs_pkg::ACC_W-1:0]  lane_sum [lbs_pkg::LANES],
   output lbs_pkg::lane_ctrl_type            lane_ctrl,
   output logic                              busy,
   output logic                              rsp_valid,
   output logic signed [31:0]                out_pos_x,
   output logic signed [31:0]                out_pos_y,
   output logic signed [31:0]                out_pos_z,
   output logic signed [15:0]                out_nrm_x,
   output logic signed [15:0]                out_nrm_y,
   output logic signed [15:0]                out_nrm_z
);
   import lbs_pkg::*;

   state_type               state_ff, state_in;

   logic [2:0]              g_ff;
   logic [WSUM_W-1:0]       wsum_ff;
   logic [3:0]              ei_ff;
   logic signed [31:0]      e_ff [LANES];
   logic [1:0]              mr_ff, mc_ff;
   logic                    mk_ff;
   logic                    issue_ff;
   logic signed [63:0]      prod_ff;
   logic                    prod_v_ff;
   mul_kind_type            prod_kind_ff;
   logic [1:0]              prod_r_ff;
   logic signed [XACC_W-1:0] pos_acc_ff [3];
   logic signed [XACC_W-1:0] nrm_acc_ff [3];
   logic [MAG_W-1:0]        mag_ff [3];
   logic                    neg_ff [3];
   logic [SQ_IN_W-1:0]      sumsq_ff;
   logic [SQ_OUT_W-1:0]     len_ff;
   logic [1:0]              nr_ff;
   logic                    rsp_valid_ff;
   logic signed [31:0]      out_pos_ff [3];
   logic signed [15:0]      out_nrm_ff [3];

   // influence decode
   logic [7:0]              j_arr [INFL];
   logic [15:0]             w_arr [INFL];
   logic                    cnt_arr [INFL];
   logic                    gather_issue;

   // element normalization
   logic signed [ACC_W-1:0] sel_sum;
   logic                    w_zero, w_band, sum_neg;
   logic [DIV_NUM_W-1:0]    sum_abs;
   logic signed [63:0]      s_ext;
   logic signed [31:0]      elem_rnd, elem_div;
   logic signed [63:0]      q_s;

   // shared units
   logic                    div_start, div_done;
   logic [DIV_NUM_W-1:0]    div_num, div_quo;
   logic [DIV_DEN_W-1:0]    div_den;
   logic                    sq_start, sq_done;
   logic [SQ_OUT_W-1:0]     sq_root;
   logic                    mul_go;
   logic signed [31:0]      mul_a, mul_b;
   mul_kind_type            mul_kind;
   logic signed [63:0]      prod_rnd;
   logic                    mag_hi;
   logic [MAG_W-1:0]        sel_mag;
   logic                    sel_neg;
   logic [14:0]             nq;
   logic signed [15:0]      nrm_q;
   logic signed [31:0]      sel_pos;
   logic signed [15:0]      sel_nrm;

   always_comb begin
      for (int k = 0; k < INFL; k++) begin
         j_arr[k] = joint_indices[8*k +: 8];
         w_arr[k] = (k < 2) ? weights_01[16*(k%2) +: 16] : weights_23[16*(k%2) +: 16];
         cnt_arr[k] = (w_arr[k] != 16'd0) && ({1'b0, j_arr[k]} < limit);
      end
   end

   assign gather_issue = (state_ff == ST_GATHER) && !g_ff[2] && cnt_arr[g_ff[1:0]];

   assign sel_sum  = lane_sum[ei_ff];
   assign w_zero   = (wsum_ff == '0);
   assign w_band   = (wsum_ff >= WSUM_LO) && (wsum_ff <= WSUM_HI);
   assign sum_neg  = sel_sum[ACC_W-1];
   assign sum_abs  = sum_neg ? DIV_NUM_W'(-sel_sum) : DIV_NUM_W'(sel_sum);
   assign s_ext    = $signed({{(64-ACC_W){sel_sum[ACC_W-1]}}, sel_sum});
   assign elem_rnd = sat32((s_ext + 64'sd16384) >>> 15);
   assign q_s      = $signed({{(64-DIV_NUM_W){1'b0}}, div_quo});
   assign elem_div = sat32(sum_neg ? -q_s : q_s);

   assign mag_hi = (|mag_ff[0][MAG_W-1:NMAG_W]) || (|mag_ff[1][MAG_W-1:NMAG_W])
                || (|mag_ff[2][MAG_W-1:NMAG_W]);

   always_comb begin
      case (nr_ff)
         2'd0: begin
            sel_mag = mag_ff[0];
            sel_neg = neg_ff[0];
         end
         2'd1: begin
            sel_mag = mag_ff[1];
            sel_neg = neg_ff[1];
         end
         default: begin
            sel_mag = mag_ff[2];
            sel_neg = neg_ff[2];
         end
      endcase
   end

   assign nq    = (div_quo > DIV_NUM_W'(NRM_MAX)) ? NRM_MAX : div_quo[14:0];
   assign nrm_q = sel_neg ? -$signed({1'b0, nq}) : $signed({1'b0, nq});

   // divider operands: matrix normalization or normal renormalization
   always_comb begin
      if (state_ff == ST_NDIV || state_ff == ST_NDIV_WAIT) begin
         div_num = {{(DIV_NUM_W-NMAG_W-14){1'b0}}, sel_mag[NMAG_W-1:0], 14'b0}
                 + {{(DIV_NUM_W-SQ_OUT_W+1){1'b0}}, len_ff[SQ_OUT_W-1:1]};
         div_den = len_ff;
      end else begin
         div_num = sum_abs + {{(DIV_NUM_W-WSUM_W+1){1'b0}}, wsum_ff[WSUM_W-1:1]};
         div_den = DIV_DEN_W'(wsum_ff);
      end
   end

   // multiplier operands
   always_comb begin
      case (mc_ff)
         2'd0: begin
            sel_pos = pos_x;
            sel_nrm = nrm_x;
         end
         2'd1: begin
            sel_pos = pos_y;
            sel_nrm = nrm_y;
         end
         default: begin
            sel_pos = pos_z;
            sel_nrm = nrm_z;
         end
      endcase
      if (state_ff == ST_SQUARE) begin
         case (mr_ff)
            2'd0:    mul_a = $signed({2'b0, mag_ff[0][NMAG_W-1:0]});
            2'd1:    mul_a = $signed({2'b0, mag_ff[1][NMAG_W-1:0]});
            default: mul_a = $signed({2'b0, mag_ff[2][NMAG_W-1:0]});
         endcase
         mul_b    = mul_a;
         mul_kind = MUL_SQR;
      end else begin
         mul_a    = e_ff[{mr_ff, mc_ff}];
         mul_b    = mk_ff ? 32'(sel_nrm) : sel_pos;
         mul_kind = mk_ff ? MUL_NRM : MUL_POS;
      end
   end

   assign prod_rnd = (prod_ff + 64'sd32768) >>> 16;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (start) state_in = ST_GATHER;
         ST_GATHER:    if (g_ff == 3'd5) state_in = ST_ELEM;
         ST_ELEM: begin
            if (w_zero || w_band) begin
               state_in = (ei_ff == 4'(LANES - 1)) ? ST_XINIT : ST_ELEM;
            end else begin
               state_in = ST_ELEM_WAIT;
            end
         end
         ST_ELEM_WAIT: if (div_done) begin
            state_in = (ei_ff == 4'(LANES - 1)) ? ST_XINIT : ST_ELEM;
         end
         ST_XINIT:     state_in = ST_XFORM;
         ST_XFORM:     if (!issue_ff && !prod_v_ff) state_in = ST_SHIFT;
         ST_SHIFT:     if (!mag_hi) state_in = ST_SQUARE;
         ST_SQUARE:    if (!issue_ff && !prod_v_ff) state_in = ST_SQRT;
         ST_SQRT:      if (sq_done) state_in = ST_NDIV;
         ST_NDIV: begin
            if (len_ff == '0) begin
               state_in = (nr_ff == 2'd2) ? ST_DONE : ST_NDIV;
            end else begin
               state_in = ST_NDIV_WAIT;
            end
         end
         ST_NDIV_WAIT: if (div_done) state_in = (nr_ff == 2'd2) ? ST_DONE : ST_NDIV;
         ST_DONE:      state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // unit strobes
   always_comb begin
      div_start        = 1'b0;
      sq_start         = 1'b0;
      mul_go           = 1'b0;
      lane_ctrl.clear  = 1'b0;
      lane_ctrl.issue  = gather_issue;
      lane_ctrl.joint  = j_arr[g_ff[1:0]];
      lane_ctrl.weight = w_arr[g_ff[1:0]];
      case (state_ff)
         ST_IDLE:   lane_ctrl.clear = start;
         ST_ELEM:   div_start = !w_zero && !w_band;
         ST_NDIV:   div_start = (len_ff != '0);
         ST_XFORM:  mul_go = issue_ff;
         ST_SQUARE: begin
            mul_go   = issue_ff;
            sq_start = !issue_ff && !prod_v_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issue_ff     <= 1'b0;
         prod_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prod_v_ff    <= mul_go;
         rsp_valid_ff <= (state_ff == ST_DONE);
         if (state_ff == ST_XINIT || (state_ff == ST_SHIFT && !mag_hi)) begin
            issue_ff <= 1'b1;
         end else if (mul_go) begin
            if (state_ff == ST_SQUARE) begin
               if (mr_ff == 2'd2) issue_ff <= 1'b0;
            end else if (mk_ff && mc_ff == 2'd2 && mr_ff == 2'd2) begin
               issue_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start && state_ff == ST_IDLE) begin
         g_ff    <= '0;
         wsum_ff <= '0;
         ei_ff   <= '0;
      end
      if (state_ff == ST_GATHER) begin
         g_ff <= g_ff + 3'd1;
         if (gather_issue) begin
            wsum_ff <= wsum_ff + WSUM_W'(w_arr[g_ff[1:0]]);
         end
      end
      if (state_ff == ST_ELEM) begin
         if (w_zero) begin
            e_ff[ei_ff] <= is_diag(ei_ff) ? Q16_ONE : 32'sd0;
         end else if (w_band) begin
            e_ff[ei_ff] <= elem_rnd;
         end
         if (w_zero || w_band) ei_ff <= ei_ff + 4'd1;
      end
      if (state_ff == ST_ELEM_WAIT && div_done) begin
         e_ff[ei_ff] <= elem_div;
         ei_ff       <= ei_ff + 4'd1;
      end
      if (state_ff == ST_XINIT) begin
         for (int r = 0; r < 3; r++) begin
            pos_acc_ff[r] <= XACC_W'(e_ff[4*r + 3]);
            nrm_acc_ff[r] <= '0;
         end
         mr_ff <= '0;
         mc_ff <= '0;
         mk_ff <= 1'b0;
      end
      // issue one product; step the row counter when squaring, else the kind, column and row counters
      if (mul_go) begin
         prod_ff      <= mul_a * mul_b;
         prod_kind_ff <= mul_kind;
         prod_r_ff    <= mr_ff;
         if (state_ff == ST_SQUARE) begin
            mr_ff <= mr_ff + 2'd1;
         end else begin
            mk_ff <= ~mk_ff;
            if (mk_ff) begin
               if (mc_ff == 2'd2) begin
                  mc_ff <= '0;
                  mr_ff <= mr_ff + 2'd1;
               end else begin
                  mc_ff <= mc_ff + 2'd1;
               end
            end
         end
      end
      if (prod_v_ff) begin
         for (int r = 0; r < 3; r++) begin
            if (prod_r_ff == 2'(r)) begin
               case (prod_kind_ff)
                  MUL_POS: pos_acc_ff[r] <= pos_acc_ff[r] + $signed(prod_rnd[XACC_W-1:0]);
                  MUL_NRM: nrm_acc_ff[r] <= nrm_acc_ff[r] + $signed(prod_ff[XACC_W-1:0]);
                  default: ;
               endcase
            end
         end
         if (prod_kind_ff == MUL_SQR) begin
            sumsq_ff <= sumsq_ff + prod_ff[SQ_IN_W-1:0];
         end
      end
      if (state_ff == ST_XFORM && !issue_ff && !prod_v_ff) begin
         for (int r = 0; r < 3; r++) begin
            neg_ff[r] <= nrm_acc_ff[r][XACC_W-1];
            mag_ff[r] <= nrm_acc_ff[r][XACC_W-1] ? MAG_W'(-nrm_acc_ff[r])
                                                   : MAG_W'(nrm_acc_ff[r]);
         end
      end
      if (state_ff == ST_SHIFT) begin
         if (mag_hi) begin
            for (int r = 0; r < 3; r++) mag_ff[r] <= mag_ff[r] >> 1;
         end else begin
            sumsq_ff <= '0;
            mr_ff    <= '0;
         end
      end
      if (state_ff == ST_SQRT && sq_done) begin
         len_ff <= sq_root;
         nr_ff  <= '0;
      end
      if (state_ff == ST_NDIV && len_ff == '0) begin
         out_nrm_ff[nr_ff] <= 16'sd0;
         nr_ff             <= nr_ff + 2'd1;
      end
      if (state_ff == ST_NDIV_WAIT && div_done) begin
         out_nrm_ff[nr_ff] <= nrm_q;
         nr_ff             <= nr_ff + 2'd1;
      end
      if (state_ff == ST_DONE) begin
         for (int r = 0; r < 3; r++) begin
            out_pos_ff[r] <= sat32(64'(pos_acc_ff[r]));
         end
      end
   end

   lbs_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   lbs_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .val   (sumsq_ff),
      .done  (sq_done),
      .root  (sq_root)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_pos_x = out_pos_ff[0];
   assign out_pos_y = out_pos_ff[1];
   assign out_pos_z = out_pos_ff[2];
   assign out_nrm_x = out_nrm_ff[0];
   assign out_nrm_y = out_nrm_ff[1];
   assign out_nrm_z = out_nrm_ff[2];

endmodule

FILE: hw/rtl/linear_blend_vertex_skinning_top.sv
// Top level of the linear blend skinning block: request capture, palette write
// decode, twelve element lanes and the merge sequencer. Depends on lbs_pkg, lbs_lane, lbs_merge.
//
//   channel   ports                          handshake
//   request   start, busy, req_*             taken when start is high and busy is low
//   response  rsp_valid, rsp_out_*           one-cycle strobe, cannot be held off
//   csr       csr_we, csr_wdata              palette_size written when csr_we is high
//
// A palette write request is written in the cycle it is taken and leaves busy low.
// A vertex request keeps busy high; its job grows longer with each normalizing shift of
// the normal (up to 18) and with each division: one division per matrix element when
// the weight sum is neither zero nor close to one, and one per normal component when
// the normal is not zero. Both kinds of division share the one-bit-per-cycle divider.
// The response strobe follows in the first cycle with busy low.
// Reset clears palette_size and the sequencer; palette contents are undefined until written.
module linear_blend_vertex_skinning_top #(
   parameter int MAX_JOINTS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_type,
   input  logic [9:0]         req_palette_addr,
   input  logic signed [31:0] req_palette_value,
   input  logic [31:0]        req_joint_indices,
   input  logic [31:0]        req_weights_01,
   input  logic [31:0]        req_weights_23,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [15:0] req_nrm_x,
   input  logic signed [15:0] req_nrm_y,
   input  logic signed [15:0] req_nrm_z,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_out_pos_x,
   output logic signed [31:0] rsp_out_pos_y,
   output logic signed [31:0] rsp_out_pos_z,
   output logic signed [15:0] rsp_out_nrm_x,
   output logic signed [15:0] rsp_out_nrm_y,
   output logic signed [15:0] rsp_out_nrm_z,
   input  logic               csr_we,
   input  logic [6:0]         csr_wdata
);
   import lbs_pkg::*;

   localparam int STORE_DEPTH = MAX_JOINTS * 12;

   logic                    accept;
   logic                    vtx_start;
   logic [6:0]              psize_ff;
   logic [8:0]              limit;
   logic [31:0]             ji_ff, w01_ff, w23_ff;
   logic signed [31:0]      px_ff, py_ff, pz_ff;
   logic signed [15:0]      nx_ff, ny_ff, nz_ff;
   logic [19:0]             addr_prod;
   logic [6:0]              wr_row;
   logic [3:0]              wr_lane;
   logic                    wr_hit;
   lane_wr_type             lane_wr [LANES];
   lane_ctrl_type           lane_ctrl;
   logic signed [ACC_W-1:0] lane_sum [LANES];

   assign accept    = start && !busy;
   assign vtx_start = accept && req_type;

   // palette size register; clamp to the store for the influence test
   always_ff @(posedge clock) begin
      if (reset) begin
         psize_ff <= '0;
      end else if (csr_we) begin
         psize_ff <= csr_wdata;
      end
   end

   assign limit = ({2'b0, psize_ff} > 9'(MAX_JOINTS)) ? 9'(MAX_JOINTS) : {2'b0, psize_ff};

   // hold the vertex fields for the whole job
   always_ff @(posedge clock) begin
      if (vtx_start) begin
         ji_ff  <= req_joint_indices;
         w01_ff <= req_weights_01;
         w23_ff <= req_weights_23;
         px_ff  <= req_pos_x;
         py_ff  <= req_pos_y;
         pz_ff  <= req_pos_z;
         nx_ff  <= req_nrm_x;
         ny_ff  <= req_nrm_y;
         nz_ff  <= req_nrm_z;
      end
   end

   // split the word address into joint row and element lane; drop addresses past the store
   assign addr_prod = req_palette_addr * DIV12_MUL;
   assign wr_row    = addr_prod[DIV12_SHIFT +: 7];
   assign wr_lane   = 4'(req_palette_addr - 10'(wr_row * 4'd12));
   assign wr_hit    = accept && !req_type && ({2'b0, req_palette_addr} < 12'(STORE_DEPTH));

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      always_comb begin
         lane_wr[i].en   = wr_hit && (wr_lane == 4'(i));
         lane_wr[i].row  = {1'b0, wr_row};
         lane_wr[i].data = req_palette_value;
      end

      lbs_lane #(
         .MAX_JOINTS (MAX_JOINTS)
      ) u_lane (
         .clock (clock),
         .reset (reset),
         .wr    (lane_wr[i]),
         .ctrl  (lane_ctrl),
         .sum   (lane_sum[i])
      );
   end

   lbs_merge u_merge (
      .clock         (clock),
      .reset         (reset),
      .start         (vtx_start),
      .limit         (limit),
      .joint_indices (ji_ff),
      .weights_01    (w01_ff),
      .weights_23    (w23_ff),
      .pos_x         (px_ff),
      .pos_y         (py_ff),
      .pos_z         (pz_ff),
      .nrm_x         (nx_ff),
      .nrm_y         (ny_ff),
      .nrm_z         (nz_ff),
      .lane_sum      (lane_sum),
      .lane_ctrl     (lane_ctrl),
      .busy          (busy),
      .rsp_valid     (rsp_valid),
      .out_pos_x     (rsp_out_pos_x),
      .out_pos_y     (rsp_out_pos_y),
      .out_pos_z     (rsp_out_pos_z),
      .out_nrm_x     (rsp_out_nrm_x),
      .out_nrm_y     (rsp_out_nrm_y),
      .out_nrm_z     (rsp_out_nrm_z)
   );

endmodule
